### hw/rtl/xor_checked_frame_receiver_core_macros.svh
// Assertion macros for the xor-checked frame receiver.
// Used by the port checker; needs nothing else.
`ifndef XOR_CHECKED_FRAME_RECEIVER_CORE_MACROS_SVH
`define XOR_CHECKED_FRAME_RECEIVER_CORE_MACROS_SVH

// Property checked on every clock edge outside reset
`define XCFR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("xcfr assertion failed");

// Property checked on every clock edge, reset included
`define XCFR_ASSERT_ALL(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("xcfr assertion failed");

`endif

### hw/rtl/xcfr_pkg.sv
// Package for the xor-checked frame receiver: header characters, phase and
// result kind codes, and the result word type. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package xcfr_pkg;

   // Header characters
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_B      = 8'h42;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LT     = 8'h3C;

   // Receiver phase, one-hot
   typedef enum logic [3:0] {
      PH_HUNT = 4'b0001,
      PH_LEN  = 4'b0010,
      PH_ID   = 4'b0100,
      PH_DATA = 4'b1000
   } phase_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_ACCEPT  = 2'd1,
      KIND_REJECT  = 2'd2
   } kind_type;

   // One result word
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic [7:0] byte_index;
      logic [7:0] message_id;
      logic [7:0] payload_length;
      logic       direction;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/xcfr_parser.sv
// Frame parser: header hunt, length/id capture, payload tagging and XOR check.
// Depends on xcfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xcfr_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               byte_valid,
   input  wire logic [7:0]         rx_byte,
   output logic                    res_valid,
   output xcfr_pkg::result_type    res
);
   import xcfr_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [1:0] hdr_ff, hdr_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] id_ff, id_in;
   logic [7:0] len_ff, len_in;
   logic       dir_ff, dir_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] pos_ff, pos_in;

   // Next state and result for the byte on the input
   always_comb begin
      phase_in  = phase_ff;
      hdr_in    = hdr_ff;
      left_in   = left_ff;
      id_in     = id_ff;
      len_in    = len_ff;
      dir_in    = dir_ff;
      xor_in    = xor_ff;
      pos_in    = pos_ff;
      res_valid = 1'b0;
      res.kind           = KIND_PAYLOAD;
      res.data           = rx_byte;
      res.byte_index     = pos_ff;
      res.message_id     = id_ff;
      res.payload_length = len_ff;
      res.direction      = dir_ff;

      unique case (phase_ff)
         PH_LEN: begin
            len_in   = rx_byte;
            left_in  = rx_byte;
            xor_in   = rx_byte;
            pos_in   = 8'd0;
            phase_in = PH_ID;
         end
         PH_ID: begin
            id_in    = rx_byte;
            xor_in   = xor_ff ^ rx_byte;
            phase_in = PH_DATA;
         end
         PH_DATA: begin
            res_valid = byte_valid;
            if (left_ff == 8'd0) begin
               // checksum byte closes the frame
               res.kind       = (xor_ff == rx_byte) ? KIND_ACCEPT : KIND_REJECT;
               res.byte_index = 8'd0;
               phase_in       = PH_HUNT;
               hdr_in         = 2'd0;
            end else begin
               xor_in  = xor_ff ^ rx_byte;
               pos_in  = pos_ff + 8'd1;
               left_in = left_ff - 8'd1;
            end
         end
         default: begin
            // sliding header match, restarting on '$'
            priority if (hdr_ff == 2'd2 && (rx_byte == CH_GT || rx_byte == CH_LT)) begin
               dir_in   = (rx_byte == CH_LT);
               hdr_in   = 2'd0;
               phase_in = PH_LEN;
            end else if (hdr_ff == 2'd1 && rx_byte == CH_B) begin
               hdr_in = 2'd2;
            end else if (rx_byte == CH_DOLLAR) begin
               hdr_in = 2'd1;
            end else begin
               hdr_in = 2'd0;
            end
         end
      endcase
   end

   // State registers, updated once per consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         hdr_ff   <= 2'd0;
         left_ff  <= 8'd0;
         id_ff    <= 8'd0;
         len_ff   <= 8'd0;
         dir_ff   <= 1'b0;
         xor_ff   <= 8'd0;
         pos_ff   <= 8'd0;
      end else if (byte_valid) begin
         phase_ff <= phase_in;
         hdr_ff   <= hdr_in;
         left_ff  <= left_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         dir_ff   <= dir_in;
         xor_ff   <= xor_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/xcfr_out_stage.sv
// Result register with valid/ready towards the consumer.
// Depends on xcfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xcfr_out_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  res_valid,
   input  wire xcfr_pkg::result_type  res,
   output logic                       load_ok,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output xcfr_pkg::result_type       out_word
);
   import xcfr_pkg::*;

   logic       valid_ff, valid_in;
   result_type word_ff;

   // Register is free when empty or being drained this cycle
   assign load_ok  = !valid_ff || out_ready;
   assign valid_in = res_valid ? 1'b1 : (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (res_valid) begin
         word_ff <= res;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

### hw/rtl/xor_checked_frame_receiver_core.sv
// Top level of the xor-checked frame receiver: input register, parser and
// result register. Depends on xcfr_pkg, xcfr_parser and xcfr_out_stage.
//
//   channel  dir  ports                                   word
//   req      in   req_valid / req_ready                   req_rx_byte
//   rsp      out  rsp_valid / rsp_ready                   rsp_kind .. rsp_direction
//
// One byte is taken per cycle while the result register is not stalled;
// a result passes through the input register and then the result register.
// Reset clears the header hunt, the frame state and both valid flags.
// A stalled result register holds the input register, which then holds req.
`timescale 1ns / 1ps
`default_nettype none

module xor_checked_frame_receiver_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_data,
   output logic [7:0]      rsp_byte_index,
   output logic [7:0]      rsp_message_id,
   output logic [7:0]      rsp_payload_length,
   output logic            rsp_direction
);
   import xcfr_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       load_ok;
   logic       res_valid;
   result_type res;
   result_type out_word;

   // Input word moves on when the result register can take a result
   assign advance     = in_valid_ff && load_ok;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) ? 1'b1 : (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   xcfr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (advance),
      .rx_byte    (in_byte_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   xcfr_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .load_ok   (load_ok),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (out_word)
   );

   assign rsp_kind           = out_word.kind;
   assign rsp_data           = out_word.data;
   assign rsp_byte_index     = out_word.byte_index;
   assign rsp_message_id     = out_word.message_id;
   assign rsp_payload_length = out_word.payload_length;
   assign rsp_direction      = out_word.direction;

endmodule

`default_nettype wire

### hw/rtl/xcfr_checker.sv
// Port checker for the xor-checked frame receiver, bound to the top level.
// Depends on xcfr_pkg and xor_checked_frame_receiver_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "xor_checked_frame_receiver_core_macros.svh"

module xcfr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_kind,
   input wire logic [7:0] rsp_data,
   input wire logic [7:0] rsp_byte_index,
   input wire logic [7:0] rsp_payload_length
);
   import xcfr_pkg::*;

   // no result word straight out of reset
   `XCFR_ASSERT_ALL(a_idle_after_reset, clock, $past(reset) |-> !rsp_valid)
   // a stalled result word holds
   `XCFR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_kind))
   // payload index stays inside the declared length
   `XCFR_ASSERT(a_index_range, clock, reset, rsp_valid && rsp_kind == KIND_PAYLOAD |-> rsp_byte_index < rsp_payload_length)
   // end-of-frame words carry index zero
   `XCFR_ASSERT(a_eof_index, clock, reset, rsp_valid && (rsp_kind == KIND_ACCEPT || rsp_kind == KIND_REJECT) |-> rsp_byte_index == 8'd0)
   // with the result side drained, the input side is open
   `XCFR_ASSERT(a_ready_when_drained, clock, reset, !rsp_valid && !$past(req_valid && req_ready) |-> req_ready)

endmodule

bind xor_checked_frame_receiver_core xcfr_checker u_xcfr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_kind           (rsp_kind),
   .rsp_data           (rsp_data),
   .rsp_byte_index     (rsp_byte_index),
   .rsp_payload_length (rsp_payload_length)
);

`default_nettype wire
